FILE: rtl/lstfs_pkg.sv
// shared types, codes and helper functions for the led slot table frame sender
// no dependencies; used by every module of the block
package lstfs_pkg;

	localparam int LED_SLOTS_DEF = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] FRAME_END = 8'hfe;
	localparam logic [7:0] FILL_BYTE = 8'h05;

	// input opcodes
	localparam logic [1:0] OP_LIGHT = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_SEND = 2'd2;

	// byte position within one led record
	localparam logic [2:0] PH_HUND = 3'd0;
	localparam logic [2:0] PH_TENS = 3'd1;
	localparam logic [2:0] PH_ONES = 3'd2;
	localparam logic [2:0] PH_LAST = 3'd5;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] note;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LIGHT,
		CMD_CLEAR,
		CMD_SEND
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [6:0] led;
	} cmd_t;

	function automatic logic [6:0] note_to_led(input logic [6:0] note);
		logic [6:0] led;
		begin
			case (note)
				7'd60: led = 7'd81;
				7'd62: led = 7'd85;
				7'd64: led = 7'd89;
				7'd65: led = 7'd91;
				7'd67: led = 7'd95;
				7'd69: led = 7'd99;
				7'd71: led = 7'd103;
				7'd72: led = 7'd105;
				7'd74: led = 7'd109;
				7'd76: led = 7'd113;
				7'd77: led = 7'd115;
				default: led = note;
			endcase
			return led;
		end
	endfunction

	// byte of one led record: three ascii digits, then three fill bytes
	function automatic logic [7:0] record_byte(input logic [6:0] v, input logic [2:0] phase);
		logic       hund;
		logic [6:0] rem;
		logic [14:0] prod;
		logic [3:0] tens;
		logic [6:0] ones;
		logic [7:0] b;
		begin
			hund = (v >= 7'd100);
			rem  = hund ? (v - 7'd100) : v;
			// divide by ten via reciprocal, exact for every 7-bit value of rem
			prod = 15'(rem) * 15'd205;
			tens = prod[14:11];
			ones = rem - 7'(tens) * 7'd10;
			case (phase)
				PH_HUND: b = DIGIT_BASE + 8'(hund);
				PH_TENS: b = DIGIT_BASE + 8'(tens);
				PH_ONES: b = DIGIT_BASE + 8'(ones);
				default: b = FILL_BYTE;
			endcase
			return b;
		end
	endfunction

endpackage

FILE: rtl/lstfs_front.sv
// front stage: takes requests, maps notes to leds and classifies the opcode
// depends on lstfs_pkg
module lstfs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  lstfs_pkg::in_item_t  cmd,
	output logic                 push_valid,
	input  logic                 push_ready,
	output lstfs_pkg::cmd_t      push_cmd
);
	import lstfs_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;
	logic      useful;

	assign cmd_ready = !valid_s1 || push_ready;

	always_comb begin
		kind   = CMD_LIGHT;
		useful = 1'b1;
		case (cmd.op)
			OP_LIGHT: kind = CMD_LIGHT;
			OP_CLEAR: kind = CMD_CLEAR;
			OP_SEND:  kind = CMD_SEND;
			default:  useful = 1'b0; // unused opcode is dropped here
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid && useful;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1.kind <= kind;
			cmd_s1.led  <= note_to_led(cmd.note);
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

FILE: rtl/lstfs_queue.sv
// short command queue between the front stage and the slot table engine
// depends on lstfs_pkg
module lstfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  lstfs_pkg::cmd_t  push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output lstfs_pkg::cmd_t  pop_cmd
);
	import lstfs_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/lstfs_back.sv
// back end: slot table, light and clear updates, frame walk into the output register
// depends on lstfs_pkg
module lstfs_back #(
	parameter int LED_SLOTS = lstfs_pkg::LED_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  lstfs_pkg::cmd_t       pop_cmd,
	output logic                  tx_valid,
	input  logic                  tx_ready,
	output lstfs_pkg::out_item_t  tx
);
	import lstfs_pkg::*;

	localparam int SLOT_W = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
	localparam int SCAN_W = $clog2(LED_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t            state_q;
	logic [SCAN_W-1:0] scan_q;
	logic [2:0]        phase_q;
	logic              slot_used_q [LED_SLOTS];
	logic [6:0]        slot_led_q [LED_SLOTS];
	logic              tx_valid_q;
	out_item_t         tx_q;

	logic              take;
	logic              hit;
	logic [LED_SLOTS-1:0] match;
	logic              found_free;
	logic [SLOT_W-1:0] free_idx;
	logic              found_hit;
	logic [SLOT_W-1:0] hit_idx;
	logic              scan_done;
	logic [SLOT_W-1:0] slot_idx;
	logic              cur_used;
	logic [6:0]        cur_led;
	logic              out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign take      = pop_valid && pop_ready;
	assign out_free  = !tx_valid_q || tx_ready;
	assign tx_valid  = tx_valid_q;
	assign tx        = tx_q;

	// per-slot compare and first free / first match pick
	always_comb begin
		found_free = 1'b0;
		free_idx   = '0;
		found_hit  = 1'b0;
		hit_idx    = '0;
		for (int s = 0; s < LED_SLOTS; s++) begin
			match[s] = slot_used_q[s] && (slot_led_q[s] == pop_cmd.led);
			if (!found_free && !slot_used_q[s]) begin
				found_free = 1'b1;
				free_idx   = SLOT_W'(s);
			end
			if (!found_hit && match[s]) begin
				found_hit = 1'b1;
				hit_idx   = SLOT_W'(s);
			end
		end
		hit = |match;
	end

	assign scan_done = (scan_q == SCAN_W'(LED_SLOTS));
	assign slot_idx  = SLOT_W'(scan_q);
	assign cur_used  = !scan_done && slot_used_q[slot_idx];
	assign cur_led   = slot_led_q[slot_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			phase_q    <= PH_HUND;
			tx_valid_q <= 1'b0;
			for (int s = 0; s < LED_SLOTS; s++) begin
				slot_used_q[s] <= 1'b0;
			end
		end else begin
			if (tx_valid_q && tx_ready) begin
				tx_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (pop_cmd.kind)
							CMD_LIGHT: begin
								if (!hit && found_free) begin
									slot_used_q[free_idx] <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								if (found_hit) begin
									slot_used_q[hit_idx] <= 1'b0;
								end
							end
							CMD_SEND: begin
								state_q <= ST_SCAN;
								scan_q  <= '0;
								phase_q <= PH_HUND;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (out_free) begin
							tx_valid_q <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end else if (!cur_used) begin
						scan_q <= scan_q + 1'b1;
					end else if (out_free) begin
						tx_valid_q <= 1'b1;
						if (phase_q == PH_LAST) begin
							phase_q <= PH_HUND;
							scan_q  <= scan_q + 1'b1;
						end else begin
							phase_q <= phase_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_cmd.kind == CMD_LIGHT && !hit && found_free) begin
			slot_led_q[free_idx] <= pop_cmd.led;
		end
		if (state_q == ST_SCAN && out_free) begin
			if (scan_done) begin
				tx_q.frame_byte <= FRAME_END;
				tx_q.last       <= 1'b1;
			end else if (cur_used) begin
				tx_q.frame_byte <= record_byte(cur_led, phase_q);
				tx_q.last       <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/led_slot_table_frame_sender.sv
// top level of the led slot table frame sender: front stage, command queue, back end
// depends on lstfs_pkg, lstfs_front, lstfs_queue, lstfs_back
//
// Light and clear requests pass a registered front stage that maps the note to
// an LED number and a two-entry queue; the back end applies each one as it takes
// it, so they flow at one per cycle while the back end is idle. Once a send is
// taken, the back end walks the slots in order, skipping each unlit slot and
// handing each byte of a lit slot to the output register, the last byte also
// stepping to the next slot; the walk waits while that register is full, and a
// single slot walker feeds it. The front keeps taking requests while a frame is
// sent until the queue and its own register are full, and the table is read for
// the frame exactly as it stood when the send was taken.
module led_slot_table_frame_sender #(
	parameter int LED_SLOTS = lstfs_pkg::LED_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  lstfs_pkg::in_item_t   cmd,
	output logic                  tx_valid,
	input  logic                  tx_ready,
	output lstfs_pkg::out_item_t  tx
);
	import lstfs_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	lstfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	lstfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	lstfs_back #(
		.LED_SLOTS (LED_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx        (tx)
	);

endmodule

FILE: sim/led_slot_table_frame_sender_test.sv
// testbench for led_slot_table_frame_sender: predicts every frame byte from light, clear
// and send requests and checks the byte stream under random bursts, gaps and stalls
// depends on lstfs_pkg and the rtl of the block
module led_slot_table_frame_sender_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lstfs_pkg::*;

	localparam int SLOTS = LED_SLOTS_DEF;
	localparam int TAIL_CYCLES = SLOTS * 8 + 40;
	localparam int HOLD_CYCLES = 400;
	localparam int NUM_RANDOM = 250;
	localparam int MAP_LEN = 11;
	localparam logic [6:0] MAPPED_NOTE [MAP_LEN] = '{
		7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd69, 7'd71, 7'd72, 7'd74, 7'd76, 7'd77};
	localparam logic [6:0] MAPPED_LED [MAP_LEN] = '{
		7'd81, 7'd85, 7'd89, 7'd91, 7'd95, 7'd99, 7'd103, 7'd105, 7'd109, 7'd113, 7'd115};
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		in_item_t req;
		bit       wait_idle;
	} pending_req_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	in_item_t cmd = '0;
	logic     tx_valid;
	logic     tx_ready = 1'b0;
	out_item_t tx;

	pending_req_t pending_reqs[$];
	out_item_t    frame_bytes[$];
	int           mismatch_count = 0;
	int           reqs_queued = 0;
	int           reqs_taken = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_tick = 0;
	logic         hold_off = 1'b0;

	// lit table as the block should hold it
	logic       lit_used [SLOTS];
	logic [6:0] lit_led [SLOTS];

	led_slot_table_frame_sender i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.tx_valid(tx_valid),
		.tx_ready(tx_ready),
		.tx(tx)
	);

	always #5 clk = ~clk;

	function automatic logic [6:0] led_of_note(input logic [6:0] note);
		logic [6:0] led;
		led = note;
		for (int k = 0; k < MAP_LEN; k++)
			if (MAPPED_NOTE[k] == note)
				led = MAPPED_LED[k];
		return led;
	endfunction

	task automatic push_frame_byte(input logic [7:0] b, input logic is_last);
		out_item_t o;
		o.frame_byte = b;
		o.last = is_last;
		frame_bytes.push_back(o);
	endtask

	// apply one request to the lit table and queue the frame bytes it causes
	task automatic apply_led_request(input in_item_t r);
		logic [6:0] led;
		bit         done;
		int         v;
		led = led_of_note(r.note);
		done = 0;
		case (r.op)
			OP_LIGHT: begin
				for (int s = 0; s < SLOTS; s++)
					if (lit_used[s] && lit_led[s] == led)
						done = 1;
				for (int s = 0; s < SLOTS; s++)
					if (!done && !lit_used[s]) begin
						lit_used[s] = 1'b1;
						lit_led[s] = led;
						done = 1;
					end
			end
			OP_CLEAR: begin
				for (int s = 0; s < SLOTS; s++)
					if (!done && lit_used[s] && lit_led[s] == led) begin
						lit_used[s] = 1'b0;
						done = 1;
					end
			end
			OP_SEND: begin
				for (int s = 0; s < SLOTS; s++)
					if (lit_used[s]) begin
						v = int'(lit_led[s]);
						push_frame_byte(DIGIT_BASE + 8'(v / 100), 1'b0);
						push_frame_byte(DIGIT_BASE + 8'((v % 100) / 10), 1'b0);
						push_frame_byte(DIGIT_BASE + 8'(v % 10), 1'b0);
						repeat (3) push_frame_byte(FILL_BYTE, 1'b0);
					end
				push_frame_byte(FRAME_END, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_request(input logic [1:0] op, input logic [6:0] note,
			input bit wait_idle);
		pending_req_t p;
		p.req.op = op;
		p.req.note = note;
		p.wait_idle = wait_idle;
		pending_reqs.push_back(p);
		reqs_queued++;
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// request driver: bursts with random gaps, optional wait for an idle block
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				apply_led_request(cmd);
				reqs_taken++;
			end
			if (!cmd_valid || cmd_ready) begin
				if (gap_left != 0 || pending_reqs.size() == 0 ||
						(pending_reqs[0].wait_idle && frame_bytes.size() != 0)) begin
					if (gap_left != 0)
						gap_left--;
					cmd_valid <= 1'b0;
				end else begin
					cmd <= pending_reqs[0].req;
					pending_reqs.pop_front();
					cmd_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// byte sink: stall style rotates between always ready, random and periodic ready
	always @(posedge clk) begin
		if (arst_n) begin
			rx_tick++;
			case ((rx_tick / 64) % 3)
				0: tx_ready <= !hold_off;
				1: tx_ready <= !hold_off && ($urandom_range(0, 1) == 1);
				default: tx_ready <= !hold_off && (rx_tick % 4 == 0);
			endcase
		end
	end

	// long sink hold-off while requests keep coming
	initial begin
		while (reqs_taken < 60)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin : byte_monitor
		out_item_t want;
		if (arst_n && tx_valid && tx_ready) begin
			if (frame_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected frame byte %h last %b",
					tx.frame_byte, tx.last));
			end else begin
				want = frame_bytes.pop_front();
				if (tx.frame_byte !== want.frame_byte)
					report_mismatch($sformatf("frame_byte %h, predicted %h",
						tx.frame_byte, want.frame_byte));
				if (tx.last !== want.last)
					report_mismatch($sformatf("last %b on byte %h, predicted %b",
						tx.last, tx.frame_byte, want.last));
			end
		end
	end

	initial begin
		int         pick;
		logic [1:0] op;
		logic [6:0] note;
		for (int s = 0; s < SLOTS; s++) begin
			lit_used[s] = 1'b0;
			lit_led[s] = '0;
		end

		// directed: empty frame, extremes, duplicates, full table, misses, unused op
		queue_request(OP_SEND, 7'd0, 0);
		queue_request(OP_UNUSED, 7'd127, 0);
		queue_request(OP_LIGHT, 7'd0, 0);
		queue_request(OP_LIGHT, 7'd127, 0);
		queue_request(OP_LIGHT, 7'd0, 0);
		queue_request(OP_LIGHT, 7'd60, 0);
		queue_request(OP_LIGHT, 7'd81, 0);    // same led as note 60
		queue_request(OP_LIGHT, 7'd77, 0);
		queue_request(OP_LIGHT, 7'd99, 0);
		queue_request(OP_LIGHT, 7'd100, 0);
		queue_request(OP_LIGHT, 7'd76, 0);
		queue_request(OP_LIGHT, 7'd5, 0);
		queue_request(OP_LIGHT, 7'd64, 0);    // table full, dropped
		queue_request(OP_SEND, 7'd127, 0);
		queue_request(OP_CLEAR, 7'd50, 0);    // not lit
		queue_request(OP_CLEAR, 7'd0, 0);
		queue_request(OP_CLEAR, 7'd60, 0);
		queue_request(OP_LIGHT, 7'd62, 0);
		queue_request(OP_SEND, 7'd85, 0);
		queue_request(OP_UNUSED, 7'd0, 0);
		queue_request(OP_CLEAR, 7'd127, 0);
		queue_request(OP_LIGHT, 7'd109, 0);
		queue_request(OP_SEND, 7'd42, 0);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = OP_LIGHT;
			else if (pick < 68)
				op = OP_CLEAR;
			else if (pick < 95)
				op = OP_SEND;
			else
				op = OP_UNUSED;
			// mostly a small pool so clears hit and the table fills
			pick = $urandom_range(0, 9);
			if (pick < 4)
				note = MAPPED_NOTE[$urandom_range(0, MAP_LEN - 1)];
			else if (pick < 6)
				note = 7'($urandom_range(0, 7));
			else
				note = 7'($urandom_range(0, 127));
			queue_request(op, note, i == 0 || i == NUM_RANDOM / 2);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs_taken < reqs_queued || frame_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (frame_bytes.size() != 0)
			report_mismatch($sformatf("%0d frame bytes never sent", frame_bytes.size()));
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
